@@ rtl/bprm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block peak / RMS meter package
// Widths, window limit and the control and status records shared between the
// sequencer, the accumulator and the root unit.
// ----------------------------------------------------------------------------
package bprm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 4096;
  localparam int COUNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int SUM_W       = PROD_W + $clog2(MAX_WINDOW) - 1;
  localparam int MEAN_W      = 32;
  localparam int ROOT_W      = MEAN_W / 2;
  localparam int SUB_W       = ROOT_W + 4;
  localparam int STEP_W      = 6;
  localparam int DIV_STEPS   = SUM_W;
  localparam int SQRT_STEPS  = ROOT_W;

  localparam logic [COUNT_W-1:0] WINDOW_LIMIT = COUNT_W'(MAX_WINDOW);

  typedef struct packed {
    logic load;
    logic square;
    logic add;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic [SUM_W-1:0]       square_sum;
    logic [COUNT_W-1:0]     sample_count;
    logic [SAMPLE_BITS-1:0] peak_so_far;
    logic                   overflow_seen;
  } acc_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

`default_nettype wire

@@ rtl/bprm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block peak / RMS meter channels
// Valid/ready channels for audio samples and for window results.
// ----------------------------------------------------------------------------
interface bprm_sample_if;
  import bprm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface bprm_result_if;
  import bprm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] peak_magnitude;
  logic [ROOT_W-1:0]      rms_level;
  logic                   window_overflow;

  modport source (output valid, output peak_magnitude, output rms_level,
                  output window_overflow, input ready);
  modport sink (input valid, input peak_magnitude, input rms_level,
                input window_overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/bprm_accum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block peak / RMS meter accumulator
// Holds the window state: sum of squares, sample count, peak magnitude and
// the overflow flag. Squaring and summing run in two separate steps.
// ----------------------------------------------------------------------------
module bprm_accum
  import bprm_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire acc_ctrl_t                     ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output acc_stat_t                          stat
);

  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] mag_reg;
  logic                   take;
  logic [PROD_W-1:0]      product;
  logic [SUM_W-1:0]       square_sum;
  logic [COUNT_W-1:0]     sample_count;
  logic [SAMPLE_BITS-1:0] peak_so_far;
  logic                   overflow_seen;
  logic                   room;

  always_comb begin
    mag  = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
    room = (sample_count < WINDOW_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_reg <= mag;
    end
    if (ctrl.square) begin
      product <= take ? PROD_W'(mag_reg) * PROD_W'(mag_reg) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      square_sum    <= '0;
      sample_count  <= '0;
      peak_so_far   <= '0;
      overflow_seen <= 1'b0;
      take          <= 1'b0;
    end else begin
      if (ctrl.load) begin
        take <= room;
        if (room) begin
          sample_count <= sample_count + COUNT_W'(1);
          if (mag > peak_so_far) begin
            peak_so_far <= mag;
          end
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (ctrl.add) begin
        square_sum <= square_sum + SUM_W'(product);
      end
    end
  end

  always_comb begin
    stat.square_sum    = square_sum;
    stat.sample_count  = sample_count;
    stat.peak_so_far   = peak_so_far;
    stat.overflow_seen = overflow_seen;
  end

endmodule

`default_nettype wire

@@ rtl/bprm_root_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block peak / RMS meter root unit
// Restoring division of the square sum by the count, then a digit-by-digit
// square root of the mean, both on one shared compare-and-subtract unit.
// ----------------------------------------------------------------------------
module bprm_root_unit
  import bprm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               take,
  input  wire logic [SUM_W-1:0]   dividend,
  input  wire logic [COUNT_W-1:0] divisor,
  output root_stat_t              stat,
  output logic [ROOT_W-1:0]       root
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_DIV  = 4'b0010,
    R_SQRT = 4'b0100,
    R_DONE = 4'b1000
  } rstate_t;

  rstate_t             state;
  logic [STEP_W-1:0]   step;
  logic [SUM_W-1:0]    quo;
  logic [COUNT_W-1:0]  den;
  logic [COUNT_W-1:0]  rem_div;
  logic [MEAN_W-1:0]   sq_val;
  logic [ROOT_W:0]     sq_rem;
  logic [SUB_W-1:0]    sub_a;
  logic [SUB_W-1:0]    sub_b;
  logic [SUB_W:0]      diff;
  logic                ge;
  logic [SUM_W-1:0]    quo_next;

  always_comb begin
    if (state == R_SQRT) begin
      sub_a = SUB_W'({sq_rem, sq_val[MEAN_W-1 -: 2]});
      sub_b = SUB_W'({root, 2'b01});
    end else begin
      sub_a = SUB_W'({rem_div, quo[SUM_W-1]});
      sub_b = SUB_W'(den);
    end
    diff     = {1'b0, sub_a} - {1'b0, sub_b};
    ge       = !diff[SUB_W];
    quo_next = {quo[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        R_IDLE: begin
          if (start) begin
            state <= R_DIV;
            step  <= '0;
          end
        end
        R_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= R_SQRT;
            step  <= '0;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        R_SQRT: begin
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            state <= R_DONE;
            step  <= '0;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        R_DONE: begin
          if (take) begin
            state <= R_IDLE;
          end
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      R_IDLE: begin
        quo     <= dividend;
        den     <= divisor;
        rem_div <= '0;
      end
      R_DIV: begin
        quo     <= quo_next;
        rem_div <= ge ? diff[COUNT_W-1:0] : sub_a[COUNT_W-1:0];
        sq_val  <= quo_next[MEAN_W-1:0];
        sq_rem  <= '0;
        root    <= '0;
      end
      R_SQRT: begin
        sq_val <= {sq_val[MEAN_W-3:0], 2'b00};
        sq_rem <= ge ? diff[ROOT_W:0] : sub_a[ROOT_W:0];
        root   <= {root[ROOT_W-2:0], ge};
      end
      R_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.busy = (state != R_IDLE);
    stat.done = (state == R_DONE);
  end

endmodule

`default_nettype wire

@@ rtl/block_peak_rms_meter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A sample without the last flag passes the square and accumulate states
// before the next sample is accepted; after a last sample the sequencer
// starts the root unit and clears the window state, 43 division steps and 16
// square root steps follow, and the next sample waits until the result loads
// into the output register, which happens once the output is free. Reset
// clears the window state, the sequencers and the output valid flag.
// ----------------------------------------------------------------------------
// Block peak / RMS meter
// Accumulates a window of audio samples and reports its peak and RMS level.
// ----------------------------------------------------------------------------
module block_peak_rms_meter_unit
  import bprm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  bprm_sample_if.sink   audio,
  bprm_result_if.source level
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQUARE = 5'b00010,
    S_ACCUM  = 5'b00100,
    S_START  = 5'b01000,
    S_WAIT   = 5'b10000
  } state_t;

  state_t                 state;
  logic                   last_reg;
  acc_ctrl_t              acc_ctrl;
  acc_stat_t              acc_stat;
  root_stat_t             root_stat;
  logic [ROOT_W-1:0]      root;
  logic                   root_take;
  logic [SAMPLE_BITS-1:0] peak_hold;
  logic                   ovf_hold;
  logic                   out_valid;
  logic                   out_free;
  logic                   in_xfer;

  always_comb begin
    in_xfer         = audio.valid && audio.ready;
    out_free        = !out_valid || level.ready;
    root_take       = (state == S_WAIT) && root_stat.done && out_free;
    acc_ctrl.load   = in_xfer;
    acc_ctrl.square = (state == S_SQUARE);
    acc_ctrl.add    = (state == S_ACCUM);
    acc_ctrl.clear  = (state == S_START);
  end

  assign audio.ready = (state == S_IDLE);

  bprm_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (acc_ctrl),
    .sample (audio.sample),
    .stat   (acc_stat)
  );

  bprm_root_unit u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .take     (root_take),
    .dividend (acc_stat.square_sum),
    .divisor  (acc_stat.sample_count),
    .stat     (root_stat),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          state <= last_reg ? S_START : S_IDLE;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (root_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      last_reg <= audio.last;
    end
    if (state == S_START) begin
      peak_hold <= acc_stat.peak_so_far;
      ovf_hold  <= acc_stat.overflow_seen;
    end
    if (root_take) begin
      level.peak_magnitude  <= peak_hold;
      level.rms_level       <= root;
      level.window_overflow <= ovf_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (root_take) begin
      out_valid <= 1'b1;
    end else if (level.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign level.valid = out_valid;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_START) |-> !root_stat.busy)
    else $error("Root unit started while still busy.");

  a_clear_after_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_START) |=> (acc_stat.sample_count == '0 && acc_stat.square_sum == '0))
    else $error("Window state not cleared after the window closed.");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    acc_stat.sample_count <= WINDOW_LIMIT)
    else $error("Sample count exceeds the window limit.");

  a_result_from_root: assert property (@(posedge clk) disable iff (rst)
    root_take |-> (state == S_WAIT && root_stat.done))
    else $error("Result loaded without a finished root.");

endmodule

`default_nettype wire
